// ===== src/bc_pkg.sv =====
package bc_pkg;

	localparam int INPUT_BITS  = 8;
	localparam int COEF_W      = 63;
	localparam int PROD_W      = COEF_W + INPUT_BITS;
	localparam int AU_W        = PROD_W + 1;
	localparam int CNT_W       = $clog2(PROD_W);
	localparam int IN_TDATA_W  = ((2 * INPUT_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((COEF_W + 7) / 8) * 8;

	localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic              ovf;
	} res_t;

endpackage

// ===== src/bc_addsub.sv =====
module bc_addsub
	import bc_pkg::*;
(
	input  logic [AU_W-1:0] a,
	input  logic [AU_W-1:0] b,
	input  logic            sub,
	output logic [AU_W-1:0] sum
);

	// two's complement subtract when sub is set
	assign sum = a + (b ^ {AU_W{sub}}) + {{(AU_W-1){1'b0}}, sub};

endmodule

// ===== src/bc_core.sv =====
module bc_core
	import bc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [INPUT_BITS-1:0] n_total,
	input  logic [INPUT_BITS-1:0] k_chosen,
	output logic                  idle,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(INPUT_BITS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [INPUT_BITS-1:0] kk_q;
	logic [INPUT_BITS-1:0] nk_q;
	logic [INPUT_BITS-1:0] i_q;
	logic [INPUT_BITS-1:0] num_q;
	logic [INPUT_BITS-1:0] rem_q;
	logic [COEF_W-1:0]     acc_q;
	logic [PROD_W-1:0]     p_q;
	res_t                  res_q;

	logic [INPUT_BITS-1:0] half;
	logic [INPUT_BITS-1:0] kk;
	logic [INPUT_BITS:0]   r;
	logic [AU_W-1:0]       au_a;
	logic [AU_W-1:0]       au_b;
	logic                  au_sub;
	logic [AU_W-1:0]       au_sum;
	logic                  fits;

	assign half = n_total >> 1;
	assign kk   = (k_chosen > half) ? (n_total - k_chosen) : k_chosen;

	// partial remainder with the next dividend bit shifted in
	assign r = {rem_q, p_q[PROD_W-1]};

	always_comb begin
		if (state_q == ST_MUL) begin
			au_a   = {1'b0, p_q[PROD_W-2:0], 1'b0};
			au_b   = num_q[INPUT_BITS-1] ? {{(AU_W-COEF_W){1'b0}}, acc_q} : '0;
			au_sub = 1'b0;
		end else begin
			au_a   = {{(AU_W-INPUT_BITS-1){1'b0}}, r};
			au_b   = {{(AU_W-INPUT_BITS){1'b0}}, i_q};
			au_sub = 1'b1;
		end
	end

	bc_addsub u_addsub (
		.a   (au_a),
		.b   (au_b),
		.sub (au_sub),
		.sum (au_sum)
	);

	assign fits = (p_q[PROD_W-1:COEF_W] == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (k_chosen > n_total || kk == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == MUL_LAST) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					if (!fits || i_q == kk_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				kk_q  <= kk;
				nk_q  <= n_total - kk;
				i_q   <= {{(INPUT_BITS-1){1'b0}}, 1'b1};
				num_q <= n_total - kk + {{(INPUT_BITS-1){1'b0}}, 1'b1};
				acc_q <= {{(COEF_W-1){1'b0}}, 1'b1};
				p_q   <= '0;
				cnt_q <= '0;
				res_q.coef <= (k_chosen > n_total) ? '0 : {{(COEF_W-1){1'b0}}, 1'b1};
				res_q.ovf  <= 1'b0;
			end
			ST_MUL: begin
				p_q   <= au_sum[PROD_W-1:0];
				num_q <= {num_q[INPUT_BITS-2:0], 1'b0};
				rem_q <= '0;
				cnt_q <= (cnt_q == MUL_LAST) ? '0 : cnt_q + 1'b1;
			end
			ST_DIV: begin
				// restoring step: borrow clear means the quotient bit is one
				if (!au_sum[AU_W-1]) begin
					rem_q <= au_sum[INPUT_BITS-1:0];
					p_q   <= {p_q[PROD_W-2:0], 1'b1};
				end else begin
					rem_q <= r[INPUT_BITS-1:0];
					p_q   <= {p_q[PROD_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + 1'b1;
			end
			ST_CHK: begin
				acc_q <= p_q[COEF_W-1:0];
				i_q   <= i_q + 1'b1;
				num_q <= nk_q + i_q + 1'b1;
				p_q   <= '0;
				cnt_q <= '0;
				res_q.coef <= fits ? p_q[COEF_W-1:0] : COEF_MAX;
				res_q.ovf  <= !fits;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < i_q))
		else $error("division remainder not below divisor");

	a_ovf_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_q.ovf) |-> (res_q.coef == COEF_MAX))
		else $error("overflow result not saturated");

	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (i_q != '0 && i_q <= kk_q))
		else $error("iteration index out of range");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_q)))
		else $error("pending result lost");

endmodule

// ===== src/binomial_coefficient.sv =====
// Computes C(n,k) for n and k of INPUT_BITS bits each, one transaction at a time. k above n
// gives 0; otherwise k is mirrored to min(k, n-k) and the exact recurrence
// acc = acc*(n-k+i)/i runs for i = 1..min(k, n-k). Each iteration goes through
// one shared add/subtract unit: a shift-add multiply, then a restoring division,
// then a check step. k above n, k of zero and k equal to n skip the loop.
// When C(n,k) exceeds 63 bits the coefficient saturates to all ones and tuser is
// set; the loop stops at the first step that overflows. A finished result sits
// in the output register while the core accepts the next transaction.
module binomial_coefficient
	import bc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // n_total, k_chosen
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // coefficient, zero fill
	output logic                   m_tuser    // overflow
);

	logic                   start;
	logic                   core_idle;
	logic                   res_valid;
	logic                   res_ready;
	res_t                   res;
	logic                   out_valid_q;
	logic [COEF_W-1:0]      coef_q;
	logic                   ovf_q;

	assign s_tready  = core_idle;
	assign start     = s_tvalid && core_idle;
	assign res_ready = !out_valid_q || m_tready;

	bc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.n_total   (s_tdata[INPUT_BITS-1:0]),
		.k_chosen  (s_tdata[2*INPUT_BITS-1:INPUT_BITS]),
		.idle      (core_idle),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			coef_q <= res.coef;
			ovf_q  <= res.ovf;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W-COEF_W){1'b0}}, coef_q};
	assign m_tuser  = ovf_q;

endmodule
